// ===== hdl/tcw_pkg.sv =====
// Shared constants for the text console writer: geometry defaults and byte codes.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STEP = 4;

  // Fixed field widths of the stream items
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  // Attribute after reset
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd7;

  // Control bytes
  localparam logic [BYTE_W-1:0] CH_NUL = 8'd0;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'd9;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_VT  = 8'd11;
  localparam logic [BYTE_W-1:0] CH_FF  = 8'd12;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_ESC = 8'd27;

  // Command codes carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/tcw_rem.sv =====
// Shared remainder unit: reciprocal multiplication by one of two constant divisors.
`timescale 1ns / 1ps
`default_nettype none
module tcw_rem #(
  parameter int DW = 12,
  parameter int VW = 7,
  parameter int D0 = tcw_pkg::DEF_COLUMNS,
  parameter int D1 = tcw_pkg::DEF_TAB_STEP
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          sel,       // 0 divides by D0, 1 by D1
  input  wire logic [DW-1:0] dividend,
  output logic               done,
  output logic      [VW-1:0] remainder
);

  // floor(n / d) = (n * M) >> S for every DW-bit n,
  // with S = DW + ceil(log2 d) and M = ceil(2^S / d)
  localparam int S0 = DW + $clog2(D0);
  localparam int S1 = DW + $clog2(D1);
  localparam int M0 = ((1 << S0) + D0 - 1) / D0;
  localparam int M1 = ((1 << S1) + D1 - 1) / D1;
  localparam int MW = DW + 2;
  localparam int PW = DW + MW;

  localparam logic [MW-1:0] M0_W = MW'(M0);
  localparam logic [MW-1:0] M1_W = MW'(M1);
  localparam logic [DW-1:0] D0_W = DW'(D0);
  localparam logic [DW-1:0] D1_W = DW'(D1);

  logic          busy_r, busy_nxt;
  logic          phase_r, phase_nxt;
  logic          done_r, done_nxt;
  logic          sel_r, sel_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] mul_m;
  logic [DW-1:0] mul_d;
  logic [PW-1:0] prod;
  logic [DW-1:0] quo_calc;
  logic [DW-1:0] rest;

  assign mul_m    = sel_r ? M1_W : M0_W;
  assign mul_d    = sel_r ? D1_W : D0_W;
  assign prod     = PW'(dvd_r) * PW'(mul_m);
  assign quo_calc = sel_r ? DW'(prod >> S1) : DW'(prod >> S0);
  assign rest     = dvd_r - quo_r * mul_d;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    sel_nxt   = sel_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      sel_nxt   = sel;
      dvd_nxt   = dividend;
    end else if (busy_r) begin
      if (!phase_r) begin
        // take the quotient from the reciprocal product
        quo_nxt   = quo_calc;
        phase_nxt = 1'b1;
      end else begin
        // keep what the quotient leaves
        rem_nxt  = rest[VW-1:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    sel_r <= sel_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// Top level of the text console writer: command sequencer, cursor state and screen memory.
//
// Text-mode console engine for a COLUMNS x ROWS screen of 16-bit cells (character in
// bits 7..0, attribute in bits 15..8) with a linear cursor. Each input beat is either a
// write of one byte (in_tuser = 0) or a read of one cell (in_tuser = 1); every beat
// yields exactly one output beat carrying the cursor position, a cursor-update flag
// (in_tlast of a write, echoed in out_tuser) and, for reads, the cell's character and
// attribute. The block handles one beat at a time and drops in_tready while it works.
// After reset it sweeps the screen memory to zero before the first beat is taken. The
// path of each beat from acceptance to the result register: a read, NUL, ESC, attribute
// byte or backspace goes straight on to the result; a printable byte or a vertical tab
// makes one pass through the scroll check; newline, carriage return and tab first go
// through the remainder unit (reciprocal multiply, reduce, hand back) and then the scroll
// check; form feed runs a clearing sweep of the whole screen first. A write with in_tlast
// set adds a read-modify-write of the attribute stamp through the single memory port
// pair; each scroll reads and then writes every moved cell through the one memory and
// blanks the bottom row. The sequencer returns to idle before the next beat is taken.
// The result is held in an output register, so the next beat is accepted while a result
// still waits.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer #(
  parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS     = tcw_pkg::DEF_ROWS,
  parameter int TAB_STEP = tcw_pkg::DEF_TAB_STEP
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] byte_in, [18:8] cell_index, [23:19] zero
  input  wire logic        in_tlast,   // end_of_write
  input  wire logic        in_tuser,   // command: 0 write, 1 read
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [10:0] cursor_position, [18:11] cell_char,
                                       // [26:19] cell_attr, [31:27] zero
  output logic             out_tuser   // cursor_update
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CUR_W      = $clog2(CELL_COUNT + COLUMNS + TAB_STEP);
  localparam int DIV_MAX    = (COLUMNS > TAB_STEP) ? COLUMNS : TAB_STEP;
  localparam int VW         = $clog2(DIV_MAX + 1);

  localparam logic [CUR_W-1:0]  CELLS_CUR = CUR_W'(CELL_COUNT);
  localparam logic [CUR_W-1:0]  COLS_CUR  = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0]  TAB_CUR   = CUR_W'(TAB_STEP);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(CELL_COUNT - COLUMNS - 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_SCRCHK  = 4'd3;
  localparam logic [3:0] S_SCR_RD  = 4'd4;
  localparam logic [3:0] S_SCR_WR  = 4'd5;
  localparam logic [3:0] S_SCR_CLR = 4'd6;
  localparam logic [3:0] S_FLUSH   = 4'd7;
  localparam logic [3:0] S_STAMP   = 4'd8;
  localparam logic [3:0] S_RDWAIT  = 4'd9;
  localparam logic [3:0] S_EMIT    = 4'd10;

  // Line operations that go through the remainder unit
  localparam logic [1:0] OP_LF  = 2'd0;
  localparam logic [1:0] OP_CR  = 2'd1;
  localparam logic [1:0] OP_TAB = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [BYTE_W-1:0] attr_r, attr_nxt;
  logic              await_r, await_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              clr_ff_r, clr_ff_nxt;     // clearing sweep came from a form feed
  logic              cmd_r, cmd_nxt;
  logic              eow_r, eow_nxt;
  logic              in_range_r, in_range_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;
  logic              out_upd_r, out_upd_nxt;

  logic [BYTE_W-1:0]  in_byte;
  logic [INDEX_W-1:0] in_index;
  logic               accept;
  logic               is_ctrl;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic              rem_start;
  logic              rem_sel;
  logic              rem_done;
  logic [VW-1:0]     rem_value;
  logic [CUR_W-1:0]  rem_ext;

  assign in_byte  = in_tdata[7:0];
  assign in_index = in_tdata[18:8];
  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign rem_ext  = CUR_W'(rem_value);

  assign is_ctrl = (in_byte == CH_ESC) || (in_byte == CH_BS) || (in_byte == CH_NUL) ||
                   (in_byte == CH_LF) || (in_byte == CH_CR) || (in_byte == CH_TAB) ||
                   (in_byte == CH_FF) || (in_byte == CH_VT);

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    attr_nxt      = attr_r;
    await_nxt     = await_r;
    ptr_nxt       = ptr_r;
    clr_ff_nxt    = clr_ff_r;
    cmd_nxt       = cmd_r;
    eow_nxt       = eow_r;
    in_range_nxt  = in_range_r;
    op_nxt        = op_r;
    cell_nxt      = cell_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_upd_nxt   = out_upd_r;

    ram_we      = 1'b0;
    ram_waddr   = ADDR_W'(cursor_r);
    ram_wdata   = '0;
    ram_raddr   = ADDR_W'(in_index);
    rem_start   = 1'b0;
    rem_sel     = 1'b0;

    // drop the result once it is taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_tuser;
          eow_nxt      = in_tlast;
          in_range_nxt = (32'(in_index) < 32'(CELL_COUNT));
          if (in_tuser == CMD_READ) begin
            state_nxt = S_RDWAIT;
          end else if (await_r) begin
            attr_nxt  = in_byte;
            await_nxt = 1'b0;
            state_nxt = S_FLUSH;
          end else if (!is_ctrl) begin
            // store the character, advance
            ram_we     = 1'b1;
            ram_wdata  = {attr_r, in_byte};
            cursor_nxt = cursor_r + 1'b1;
            state_nxt  = S_SCRCHK;
          end else begin
            unique case (in_byte)
              CH_ESC: begin
                await_nxt = 1'b1;
                state_nxt = S_FLUSH;
              end
              CH_BS: begin
                if (cursor_r != '0) begin
                  ram_we     = 1'b1;
                  ram_waddr  = ADDR_W'(cursor_r - 1'b1);
                  cursor_nxt = cursor_r - 1'b1;
                end
                state_nxt = S_FLUSH;
              end
              CH_LF, CH_CR, CH_TAB: begin
                rem_start = 1'b1;
                if (in_byte == CH_TAB) begin
                  rem_sel = 1'b1;
                  op_nxt  = OP_TAB;
                end else begin
                  op_nxt = (in_byte == CH_LF) ? OP_LF : OP_CR;
                end
                state_nxt = S_DIV;
              end
              CH_FF: begin
                cursor_nxt = '0;
                ptr_nxt    = '0;
                clr_ff_nxt = 1'b1;
                state_nxt  = S_CLEAR;
              end
              CH_VT: begin
                cursor_nxt = cursor_r + COLS_CUR;
                state_nxt  = S_SCRCHK;
              end
              default: begin
                // NUL: ignore the byte
                state_nxt = S_FLUSH;
              end
            endcase
          end
        end
      end

      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt    = '0;
          clr_ff_nxt = 1'b0;
          state_nxt  = clr_ff_r ? S_FLUSH : S_IDLE;
        end
      end

      S_DIV: begin
        if (rem_done) begin
          unique case (op_r)
            OP_LF:   cursor_nxt = cursor_r - rem_ext + COLS_CUR;
            OP_TAB:  cursor_nxt = cursor_r - rem_ext + TAB_CUR;
            default: cursor_nxt = cursor_r - rem_ext;
          endcase
          state_nxt = S_SCRCHK;
        end
      end

      S_SCRCHK: begin
        if (cursor_r >= CELLS_CUR) begin
          ptr_nxt   = '0;
          state_nxt = S_SCR_RD;
        end else begin
          state_nxt = S_FLUSH;
        end
      end

      S_SCR_RD: begin
        ram_raddr = ADDR_W'(ptr_r + ADDR_W'(COLUMNS));
        state_nxt = S_SCR_WR;
      end

      S_SCR_WR: begin
        // move the cell one row up
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = (ptr_r == LAST_MOVE) ? S_SCR_CLR : S_SCR_RD;
      end

      S_SCR_CLR: begin
        // blank the bottom row
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt    = '0;
          cursor_nxt = cursor_r - COLS_CUR;
          state_nxt  = S_SCRCHK;
        end
      end

      S_FLUSH: begin
        ram_raddr = ADDR_W'(cursor_r);
        state_nxt = eow_r ? S_STAMP : S_EMIT;
      end

      S_STAMP: begin
        // stamp the current attribute at the cursor, keep the character
        ram_we    = 1'b1;
        ram_wdata = {attr_r, ram_rdata[7:0]};
        state_nxt = S_EMIT;
      end

      S_RDWAIT: begin
        cell_nxt  = in_range_r ? ram_rdata : '0;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_upd_nxt   = (cmd_r == CMD_WRITE) && eow_r;
          if (cmd_r == CMD_READ) begin
            out_data_nxt = {5'd0, cell_r[15:8], cell_r[7:0], POS_W'(cursor_r)};
          end else begin
            out_data_nxt = {21'd0, POS_W'(cursor_r)};
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cursor_r    <= '0;
      attr_r      <= ATTR_RESET;
      await_r     <= 1'b0;
      ptr_r       <= '0;
      clr_ff_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      attr_r      <= attr_nxt;
      await_r     <= await_nxt;
      ptr_r       <= ptr_nxt;
      clr_ff_r    <= clr_ff_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    eow_r      <= eow_nxt;
    in_range_r <= in_range_nxt;
    op_r       <= op_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
    out_upd_r  <= out_upd_nxt;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_rem #(
    .DW (CUR_W),
    .VW (VW),
    .D0 (COLUMNS),
    .D1 (TAB_STEP)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .sel       (rem_sel),
    .dividend  (cursor_r),
    .done      (rem_done),
    .remainder (rem_value)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_upd_r;

endmodule
`default_nettype wire

// ===== tb/console_checker.sv =====
// Scoreboard for the text console writer: screen/cursor predictor and result comparison.
`timescale 1ns / 1ps
module console_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic        out_tuser,
  output int               failures,
  output int               outstanding
);
  import tcw_pkg::*;

  localparam int COLS  = DEF_COLUMNS;
  localparam int LINES = DEF_ROWS;
  localparam int TABW  = DEF_TAB_STEP;
  localparam int CELLS = COLS * LINES;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic              upd;
    logic [BYTE_W-1:0] chr;
    logic [BYTE_W-1:0] attr;
  } console_result_t;

  logic [CELL_W-1:0] screen [0:CELLS-1];
  int unsigned       cur_pos;
  logic [BYTE_W-1:0] cur_attr;
  logic              attr_next;
  console_result_t   awaited_results [$];
  int                fail_count = 0;

  // Scroll up one row at a time until the cursor is back on screen.
  task automatic scroll_to_cursor();
    while (cur_pos >= CELLS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
      cur_pos -= COLS;
    end
  endtask

  task automatic apply_byte(input logic [BYTE_W-1:0] b);
    if (attr_next) begin
      cur_attr  = b;
      attr_next = 1'b0;
    end else if (b == CH_ESC) begin
      attr_next = 1'b1;
    end else if (b == CH_BS) begin
      if (cur_pos != 0) begin
        cur_pos--;
        screen[cur_pos] = '0;
      end
    end else if (b != CH_NUL) begin
      case (b)
        CH_LF:   cur_pos = (cur_pos / COLS + 1) * COLS;
        CH_CR:   cur_pos = (cur_pos / COLS) * COLS;
        CH_TAB:  cur_pos = (cur_pos / TABW + 1) * TABW;
        CH_VT:   cur_pos += COLS;
        CH_FF: begin
          for (int i = 0; i < CELLS; i++) screen[i] = '0;
          cur_pos = 0;
        end
        default: begin
          screen[cur_pos] = {cur_attr, b};
          cur_pos++;
        end
      endcase
      scroll_to_cursor();
    end
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    console_result_t   want;
    console_result_t   got;
    logic [CELL_W-1:0] cell_word;
    logic [INDEX_W-1:0] idx;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      cur_pos   = 0;
      cur_attr  = ATTR_RESET;
      attr_next = 1'b0;
      awaited_results.delete();
    end else begin
      // The result register holds an earlier item, so compare before predicting.
      if (out_tvalid && out_tready) begin
        got.pos  = out_tdata[10:0];
        got.chr  = out_tdata[18:11];
        got.attr = out_tdata[26:19];
        got.upd  = out_tuser;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("cursor_position", want.pos, got.pos);
          check_field("cursor_update", want.upd, got.upd);
          check_field("cell_char", want.chr, got.chr);
          check_field("cell_attr", want.attr, got.attr);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_READ) begin
          idx       = in_tdata[18:8];
          cell_word = (idx < CELLS) ? screen[idx] : '0;
          want.chr  = cell_word[7:0];
          want.attr = cell_word[15:8];
          want.upd  = 1'b0;
        end else begin
          apply_byte(in_tdata[7:0]);
          if (in_tlast) screen[cur_pos][15:8] = cur_attr;
          want.chr  = '0;
          want.attr = '0;
          want.upd  = in_tlast;
        end
        want.pos = cur_pos[POS_W-1:0];
        awaited_results.push_back(want);
      end
    end
    failures    <= fail_count;
    outstanding <= awaited_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the text console writer testbench: clock, reset, beat stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import tcw_pkg::*;

  localparam int ITEM_TARGET = 1150;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tuser   = CMD_WRITE;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [31:0] out_tdata;
  wire         out_tuser;

  int failures;
  int outstanding;
  int beats_sent = 0;
  // When set, neither side inserts gaps, so back-to-back stretches occur too.
  bit steady = 1'b0;

  text_console_writer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  console_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive one beat: optionally idle first, then hold valid until accepted.
  // Valid stays high after acceptance so the next beat can follow without a gap.
  task automatic send_beat(input logic cmd, input logic [7:0] b, input logic last,
                           input logic [10:0] idx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {5'b0, idx, b};
    in_tlast  <= last;
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Writes carry a random cell_index, which the block must ignore.
  task automatic write_byte(input logic [7:0] b, input logic last);
    send_beat(CMD_WRITE, b, last, 11'($urandom_range(0, 2047)));
  endtask

  // Reads carry random byte and tlast, both ignored on reads.
  task automatic read_cell(input logic [10:0] idx);
    send_beat(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
  endtask

  // Drop valid and hold until every predicted result has come back.
  // The first edge lets the count of the last accepted beat settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Any byte that is not a control code.
  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    bit         ctrl;
    do begin
      b = 8'($urandom_range(0, 255));
      case (b)
        CH_NUL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_ESC: ctrl = 1'b1;
        default: ctrl = 1'b0;
      endcase
    end while (ctrl);
    return b;
  endfunction

  // Mostly text, with the cheap control codes mixed in and some raw bytes.
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return plain_char();
    if (r < 75) return CH_LF;
    if (r < 79) return CH_TAB;
    if (r < 83) return CH_CR;
    if (r < 87) return CH_BS;
    if (r < 91) return CH_NUL;
    if (r < 94) return CH_VT;
    if (r < 96) return CH_ESC;
    return 8'($urandom_range(0, 255));
  endfunction

  // Favor the top rows (most text lands there) and the bottom rows (scroll
  // targets), and touch the out-of-range indexes now and then.
  function automatic logic [10:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 11'($urandom_range(0, 159));
    if (r < 60) return 11'($urandom_range(1840, 1999));
    if (r < 90) return 11'($urandom_range(0, 1999));
    return 11'($urandom_range(1990, 2047));
  endfunction

  // Result side: drop ready for a random stall before each beat unless steady, then hold ready until a beat moves.
  initial begin
    int stall;
    @(posedge clk);
    wait (rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Main stimulus.
  initial begin
    int  pick;
    int  len;
    bit  pressure_done;
    pressure_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, range edges of reads, byte extremes, every
    // control code, attribute handling and the flush after skipped bytes.
    read_cell(11'd0);
    read_cell(11'd2047);
    read_cell(11'd1999);
    write_byte(8'h41, 1'b0);
    write_byte(8'hFF, 1'b0);
    write_byte(CH_NUL, 1'b1);     // flush on an ignored byte
    write_byte(CH_ESC, 1'b1);     // flush while an attribute is pending
    write_byte(8'h00, 1'b0);      // attribute byte of value zero
    write_byte(CH_ESC, 1'b0);
    write_byte(8'hFF, 1'b1);      // flush right after the attribute byte
    write_byte(8'h7A, 1'b0);
    write_byte(CH_TAB, 1'b0);
    write_byte(CH_CR, 1'b0);
    write_byte(CH_LF, 1'b0);
    write_byte(CH_VT, 1'b0);
    write_byte(CH_BS, 1'b1);
    read_cell(11'd0);
    read_cell(11'd1);
    write_byte(CH_FF, 1'b0);
    write_byte(CH_BS, 1'b1);      // backspace at home does nothing
    read_cell(11'd0);
    drain_results();

    // Random write calls, reads, descents toward the bottom (scrolling),
    // attribute changes, clears, backspace runs and raw noise beats.
    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if (!pressure_done && beats_sent >= ITEM_TARGET / 2) begin
        drain_results();
        pressure_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) write_byte(text_byte(), k == len - 1);
      end else if (pick < 61) begin
        len = $urandom_range(1, 4);
        repeat (len) read_cell(pick_index());
      end else if (pick < 67) begin
        len = $urandom_range(4, 16);
        for (int k = 0; k < len; k++) begin
          write_byte(($urandom_range(0, 2) == 0) ? CH_VT :
                     (($urandom_range(0, 5) == 0) ? CH_CR : CH_LF), k == len - 1);
        end
      end else if (pick < 73) begin
        write_byte(CH_ESC, 1'($urandom_range(0, 1)));
        write_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 76) begin
        write_byte(CH_FF, 1'($urandom_range(0, 1)));
      end else if (pick < 84) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) write_byte(CH_BS, k == len - 1);
      end else begin
        send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)));
      end
    end

    drain_results();
    // Give a stray extra beat time to show up; a scroll is the longest job.
    repeat (5000) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legitimate run (every beat scrolling).
  initial begin
    #(100_000_000);
    $display("%0t: timeout with %0d results outstanding", $time, outstanding);
    $display("** text_console_writer: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_rem.sv
hdl/text_console_writer.sv
tb/console_checker.sv
tb/testbench.sv
